// ----- sv/rcfp_pkg.sv -----
// Shared types and constants for the remote control frame parser.
`timescale 1ns / 1ps
`default_nettype none

package rcfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int MODE_W  = 3;
    localparam int CNT_W   = 6;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;

    // most items issued for one received byte
    localparam logic [CNT_W-1:0] MAX_ITEMS = 6'd48;

    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PACKET = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TILT   = 3'd4;

    localparam logic [BYTE_W-1:0] CH_MODE_LO = 8'h61; // 'a'
    localparam logic [BYTE_W-1:0] CH_MODE_HI = 8'h67; // 'g'
    localparam logic [BYTE_W-1:0] CH_LEFT    = 8'h4C; // 'L'
    localparam logic [BYTE_W-1:0] CH_RIGHT   = 8'h52; // 'R'
    localparam logic [BYTE_W-1:0] CH_PACKET  = 8'h50; // 'P'
    localparam logic [BYTE_W-1:0] CH_TILT    = 8'h41; // 'A'
    localparam logic [BYTE_W-1:0] CH_END     = 8'h2A; // '*'

    localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TILT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FILTER = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_STATUS = 6'b000010,
        S_LEFT   = 6'b000100,
        S_RIGHT  = 6'b001000,
        S_PACK   = 6'b010000,
        S_TILT   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ----- sv/remote_control_frame_parser.sv -----
// Remote control frame parser: byte decoder, frame stores and item sequencer.
// Flow: a taken byte moves the sequencer from idle to the status state, and the status item
// is loaded into the output register from there; each further item follows, with empty
// segments skipped on the way, while the sink keeps up. A new byte is taken only when the
// sequencer is idle again, after every item of the last byte is issued; the single read
// pointer walks the stores one byte a cycle while the sink keeps up.
// Reset: rst_n clears mode, flags, counts and the sequencer; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module remote_control_frame_parser #(
    parameter int JOY_FRAME_DEPTH  = 10,
    parameter int TILT_FRAME_DEPTH = 20,
    parameter int PACKET_DEPTH     = 20
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    // [7:0] rx_byte, [8] pwm_ack
    input  wire  [rcfp_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // [7:0] data, [12:8] position, [15:13] mode, [16] beep, [17] packet_ready
    output logic [rcfp_pkg::OUT_W-1:0]  m_tdata,
    // [2:0] kind
    output logic [rcfp_pkg::KIND_W-1:0] m_tuser,
    output logic                        m_tlast
);

    localparam int JCW = $clog2(JOY_FRAME_DEPTH + 1);
    localparam int JIW = $clog2(JOY_FRAME_DEPTH);
    localparam int TCW = $clog2(TILT_FRAME_DEPTH + 1);
    localparam int TIW = $clog2(TILT_FRAME_DEPTH);
    localparam int PCW = $clog2(PACKET_DEPTH + 1);
    localparam int PIW = $clog2(PACKET_DEPTH);
    localparam int CW  = rcfp_pkg::CNT_W;
    localparam int BW  = rcfp_pkg::BYTE_W;

    // persistent parser state
    logic [rcfp_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic m4_done_reg, m4_done_next;
    logic l_act_reg, l_act_next, r_act_reg, r_act_next, t_act_reg, t_act_next;
    logic p_coll_reg, p_coll_next, p_pend_reg, p_pend_next;
    logic l_first_reg, l_first_next, r_first_reg, r_first_next;
    logic [JCW-1:0] l_cnt_reg, l_cnt_next, r_cnt_reg, r_cnt_next;
    logic [TCW-1:0] t_cnt_reg, t_cnt_next;
    logic [PCW-1:0] p_cnt_reg, p_cnt_next;

    logic [BW-1:0] l_store [JOY_FRAME_DEPTH];
    logic [BW-1:0] r_store [JOY_FRAME_DEPTH];
    logic [BW-1:0] t_store [TILT_FRAME_DEPTH];
    logic [BW-1:0] p_store [PACKET_DEPTH];

    // sequencer state
    rcfp_pkg::state_t state_reg, state_next;
    logic [CW-1:0] el_reg, el_next, er_reg, er_next, ep_reg, ep_next, et_reg, et_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] n_reg, n_next;
    logic [rcfp_pkg::POS_W-1:0] idx_reg, idx_next;
    logic beep_reg, beep_next;

    // output register
    logic                        ov_reg, ov_next;
    logic [rcfp_pkg::KIND_W-1:0] o_kind_reg, o_kind_next;
    logic [BW-1:0]               o_data_reg, o_data_next;
    logic [rcfp_pkg::POS_W-1:0]  o_pos_reg, o_pos_next;
    logic [rcfp_pkg::MODE_W-1:0] o_mode_reg, o_mode_next;
    logic                        o_beep_reg, o_beep_next;
    logic                        o_pr_reg, o_pr_next;
    logic                        o_last_reg, o_last_next;

    logic [BW-1:0] b;
    logic          ack, take;
    logic          l_we, r_we, t_we, p_we;
    logic [JIW-1:0] l_wa, r_wa;
    logic [TIW-1:0] t_wa;
    logic [PIW-1:0] p_wa;
    logic [rcfp_pkg::MODE_W-1:0] mode_a;
    logic          beep_c, l_done, r_done, p_done, t_done, l_emit, r_emit;
    logic [CW+1:0] sum_c;

    logic          out_free, is_last;
    logic [CW-1:0] cur_cnt, idx_ext;
    logic [BW-1:0] cur_data;
    logic [rcfp_pkg::KIND_W-1:0] cur_kind;
    rcfp_pkg::state_t seg_after;

    assign b        = s_tdata[7:0];
    assign ack      = s_tdata[8];
    assign s_tready = (state_reg == rcfp_pkg::S_IDLE);
    assign take     = s_tvalid && s_tready;

    // byte decode: next parser state and store writes
    always_comb
    begin
        mode_next    = mode_reg;
        m4_done_next = m4_done_reg;
        l_act_next   = l_act_reg;
        r_act_next   = r_act_reg;
        t_act_next   = t_act_reg;
        p_coll_next  = p_coll_reg;
        p_pend_next  = p_pend_reg;
        l_first_next = l_first_reg;
        r_first_next = r_first_reg;
        l_cnt_next   = l_cnt_reg;
        r_cnt_next   = r_cnt_reg;
        t_cnt_next   = t_cnt_reg;
        p_cnt_next   = p_cnt_reg;
        l_we = 1'b0;
        r_we = 1'b0;
        t_we = 1'b0;
        p_we = 1'b0;
        l_wa = l_cnt_reg[JIW-1:0];
        r_wa = r_cnt_reg[JIW-1:0];
        t_wa = t_cnt_reg[TIW-1:0];
        p_wa = p_cnt_reg[PIW-1:0];
        beep_c = 1'b0;
        l_done = 1'b0;
        r_done = 1'b0;
        p_done = 1'b0;
        t_done = 1'b0;
        l_emit = 1'b0;
        r_emit = 1'b0;
        mode_a = mode_reg;

        if (ack)
        begin
            p_pend_next = 1'b0;
        end

        if (b >= rcfp_pkg::CH_MODE_LO && b <= rcfp_pkg::CH_MODE_HI)
        begin
            mode_a = rcfp_pkg::MODE_W'(b - rcfp_pkg::CH_MODE_LO + 8'd1);
            beep_c = 1'b1;
        end
        mode_next = mode_a;
        // mode 4 is cancelled the first time only
        if (!m4_done_reg && mode_a == rcfp_pkg::MODE_FILTER)
        begin
            mode_next    = rcfp_pkg::MODE_NONE;
            m4_done_next = 1'b1;
        end

        if (mode_next != rcfp_pkg::MODE_TILT)
        begin
            if (b == rcfp_pkg::CH_LEFT)
            begin
                l_act_next = 1'b1;
            end
            if (l_act_next)
            begin
                if (l_cnt_reg < JCW'(JOY_FRAME_DEPTH))
                begin
                    l_we       = 1'b1;
                    l_cnt_next = l_cnt_reg + 1'b1;
                end
                if (b == rcfp_pkg::CH_END)
                begin
                    l_done       = 1'b1;
                    l_emit       = l_first_reg;
                    l_first_next = 1'b1;
                    l_act_next   = 1'b0;
                end
            end
            if (b == rcfp_pkg::CH_RIGHT)
            begin
                r_act_next = 1'b1;
            end
            if (r_act_next)
            begin
                if (r_cnt_reg < JCW'(JOY_FRAME_DEPTH))
                begin
                    r_we       = 1'b1;
                    r_cnt_next = r_cnt_reg + 1'b1;
                end
                if (b == rcfp_pkg::CH_END)
                begin
                    r_done       = 1'b1;
                    r_emit       = r_first_reg;
                    r_first_next = 1'b1;
                    r_act_next   = 1'b0;
                end
            end
            if (!p_coll_reg)
            begin
                if (b == rcfp_pkg::CH_PACKET && !p_pend_next)
                begin
                    beep_c      = 1'b1;
                    p_coll_next = 1'b1;
                    p_cnt_next  = '0;
                end
            end
            else if (b == rcfp_pkg::CH_END)
            begin
                p_coll_next = 1'b0;
                p_pend_next = 1'b1;
                p_done      = 1'b1;
            end
            else if (p_cnt_reg < PCW'(PACKET_DEPTH))
            begin
                p_we       = 1'b1;
                p_cnt_next = p_cnt_reg + 1'b1;
            end
        end
        else
        begin
            // a tilt head restarts the frame from the first slot
            if (b == rcfp_pkg::CH_TILT)
            begin
                t_act_next = 1'b1;
                t_wa       = '0;
                t_cnt_next = '0;
            end
            if (t_act_next)
            begin
                if (t_cnt_next < TCW'(TILT_FRAME_DEPTH))
                begin
                    t_we       = 1'b1;
                    t_cnt_next = t_cnt_next + 1'b1;
                end
                if (b == rcfp_pkg::CH_END)
                begin
                    t_done     = 1'b1;
                    t_act_next = 1'b0;
                end
            end
        end

        el_next = (l_done && l_emit) ? CW'(l_cnt_next) : '0;
        er_next = (r_done && r_emit) ? CW'(r_cnt_next) : '0;
        ep_next = p_done ? CW'(p_cnt_next) : '0;
        et_next = t_done ? CW'(t_cnt_next) : '0;
        sum_c   = (CW+2)'(el_next) + (CW+2)'(er_next) + (CW+2)'(ep_next)
                + (CW+2)'(et_next) + 1'b1;
        total_next = (sum_c > (CW+2)'(rcfp_pkg::MAX_ITEMS)) ? rcfp_pkg::MAX_ITEMS
                                                              : CW'(sum_c);
        beep_next = beep_c;

        if (l_done)
        begin
            l_cnt_next = '0;
        end
        if (r_done)
        begin
            r_cnt_next = '0;
        end
        if (t_done)
        begin
            t_cnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && l_we)
        begin
            l_store[l_wa] <= b;
        end
        if (take && r_we)
        begin
            r_store[r_wa] <= b;
        end
        if (take && t_we)
        begin
            t_store[t_wa] <= b;
        end
        if (take && p_we)
        begin
            p_store[p_wa] <= b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rcfp_pkg::MODE_NONE;
            m4_done_reg <= 1'b0;
            l_act_reg   <= 1'b0;
            r_act_reg   <= 1'b0;
            t_act_reg   <= 1'b0;
            p_coll_reg  <= 1'b0;
            p_pend_reg  <= 1'b0;
            l_first_reg <= 1'b0;
            r_first_reg <= 1'b0;
            l_cnt_reg   <= '0;
            r_cnt_reg   <= '0;
            t_cnt_reg   <= '0;
            p_cnt_reg   <= '0;
        end
        else if (take)
        begin
            mode_reg    <= mode_next;
            m4_done_reg <= m4_done_next;
            l_act_reg   <= l_act_next;
            r_act_reg   <= r_act_next;
            t_act_reg   <= t_act_next;
            p_coll_reg  <= p_coll_next;
            p_pend_reg  <= p_pend_next;
            l_first_reg <= l_first_next;
            r_first_reg <= r_first_next;
            l_cnt_reg   <= l_cnt_next;
            r_cnt_reg   <= r_cnt_next;
            t_cnt_reg   <= t_cnt_next;
            p_cnt_reg   <= p_cnt_next;
        end
    end

    // item sequencer: one read pointer shared by all stores
    assign out_free = !ov_reg || m_tready;
    assign idx_ext  = CW'(idx_reg);

    always_comb
    begin
        cur_cnt   = '0;
        cur_data  = '0;
        cur_kind  = rcfp_pkg::KIND_STATUS;
        seg_after = rcfp_pkg::S_IDLE;
        unique case (state_reg)
            rcfp_pkg::S_LEFT:
            begin
                cur_cnt   = el_reg;
                cur_data  = l_store[idx_reg[JIW-1:0]];
                cur_kind  = rcfp_pkg::KIND_LEFT;
                seg_after = rcfp_pkg::S_RIGHT;
            end
            rcfp_pkg::S_RIGHT:
            begin
                cur_cnt   = er_reg;
                cur_data  = r_store[idx_reg[JIW-1:0]];
                cur_kind  = rcfp_pkg::KIND_RIGHT;
                seg_after = rcfp_pkg::S_PACK;
            end
            rcfp_pkg::S_PACK:
            begin
                cur_cnt   = ep_reg;
                cur_data  = p_store[idx_reg[PIW-1:0]];
                cur_kind  = rcfp_pkg::KIND_PACKET;
                seg_after = rcfp_pkg::S_TILT;
            end
            rcfp_pkg::S_TILT:
            begin
                cur_cnt   = et_reg;
                cur_data  = t_store[idx_reg[TIW-1:0]];
                cur_kind  = rcfp_pkg::KIND_TILT;
                seg_after = rcfp_pkg::S_IDLE;
            end
            default:
            begin
                seg_after = rcfp_pkg::S_LEFT;
            end
        endcase
    end

    assign is_last = (n_reg + 1'b1 == total_reg);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        ov_next     = ov_reg && !m_tready;
        o_kind_next = o_kind_reg;
        o_data_next = o_data_reg;
        o_pos_next  = o_pos_reg;
        o_mode_next = o_mode_reg;
        o_beep_next = o_beep_reg;
        o_pr_next   = o_pr_reg;
        o_last_next = o_last_reg;
        unique case (state_reg)
            rcfp_pkg::S_IDLE:
            begin
                if (take)
                begin
                    state_next = rcfp_pkg::S_STATUS;
                    n_next     = '0;
                    idx_next   = '0;
                end
            end
            rcfp_pkg::S_STATUS:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_kind_next = rcfp_pkg::KIND_STATUS;
                    o_data_next = '0;
                    o_pos_next  = '0;
                    o_mode_next = mode_reg;
                    o_beep_next = beep_reg;
                    o_pr_next   = p_pend_reg;
                    o_last_next = is_last;
                    n_next      = n_reg + 1'b1;
                    state_next  = is_last ? rcfp_pkg::S_IDLE : seg_after;
                end
            end
            default:
            begin
                if (cur_cnt == '0)
                begin
                    state_next = seg_after;
                end
                else if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_kind_next = cur_kind;
                    o_data_next = cur_data;
                    o_pos_next  = idx_reg;
                    o_mode_next = mode_reg;
                    o_beep_next = beep_reg;
                    o_pr_next   = p_pend_reg;
                    o_last_next = is_last;
                    n_next      = n_reg + 1'b1;
                    if (is_last)
                    begin
                        state_next = rcfp_pkg::S_IDLE;
                    end
                    else if (idx_ext + 1'b1 == cur_cnt)
                    begin
                        state_next = seg_after;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcfp_pkg::S_IDLE;
            ov_reg    <= 1'b0;
            n_reg     <= '0;
            idx_reg   <= '0;
            el_reg    <= '0;
            er_reg    <= '0;
            ep_reg    <= '0;
            et_reg    <= '0;
            total_reg <= '0;
            beep_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            if (take)
            begin
                el_reg    <= el_next;
                er_reg    <= er_next;
                ep_reg    <= ep_next;
                et_reg    <= et_next;
                total_reg <= total_next;
                beep_reg  <= beep_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        o_kind_reg <= o_kind_next;
        o_data_reg <= o_data_next;
        o_pos_reg  <= o_pos_next;
        o_mode_reg <= o_mode_next;
        o_beep_reg <= o_beep_next;
        o_pr_reg   <= o_pr_next;
        o_last_reg <= o_last_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'd0, o_pr_reg, o_beep_reg, o_mode_reg, o_pos_reg, o_data_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the remote control frame parser.
`timescale 1ns / 1ps

module tb;

    localparam int JOY_DEPTH  = 10;
    localparam int TILT_DEPTH = 20;
    localparam int PKT_DEPTH  = 20;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [rcfp_pkg::KIND_W-1:0] kind;
        logic [rcfp_pkg::BYTE_W-1:0] data;
        logic [rcfp_pkg::POS_W-1:0]  pos;
        logic [rcfp_pkg::MODE_W-1:0] mode;
        logic                        beep;
        logic                        ready;
        logic                        eof;
    } parser_item_t;

    typedef struct packed {
        logic                        ack;
        logic [rcfp_pkg::BYTE_W-1:0] rx;
    } rx_req_t;

    // {pwm_ack, rx_byte}
    localparam rx_req_t DIRECTED [27] = '{
        {1'b0, 8'h00}, {1'b1, 8'hFF},
        {1'b0, 8'h64},                          // 'd' first time: cancelled to mode 0
        {1'b0, rcfp_pkg::CH_LEFT}, {1'b0, 8'h00},
        {1'b0, 8'h62}, {1'b0, 8'h11},           // mode 2 mid-frame, byte not stored
        {1'b0, 8'h63}, {1'b0, rcfp_pkg::CH_END}, // resume, first left frame not emitted
        {1'b0, rcfp_pkg::CH_RIGHT}, {1'b0, rcfp_pkg::CH_LEFT}, {1'b0, 8'hFF},
        {1'b0, rcfp_pkg::CH_END},               // first right not emitted, left emits
        {1'b0, rcfp_pkg::CH_PACKET}, {1'b0, rcfp_pkg::CH_PACKET}, // head repeated
        {1'b0, rcfp_pkg::CH_END},
        {1'b0, rcfp_pkg::CH_PACKET},            // ignored: packet pending
        {1'b1, rcfp_pkg::CH_PACKET}, {1'b0, rcfp_pkg::CH_END}, // ack then head, empty
        {1'b0, 8'h62}, {1'b0, rcfp_pkg::CH_TILT}, {1'b0, 8'h7F},
        {1'b0, rcfp_pkg::CH_TILT}, {1'b0, rcfp_pkg::CH_END}, // tilt restarted
        {1'b0, 8'h64}, {1'b0, 8'h67}, {1'b0, 8'h61}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rcfp_pkg::IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rcfp_pkg::OUT_W-1:0] m_tdata;
    logic [rcfp_pkg::KIND_W-1:0] m_tuser;
    logic m_tlast;

    remote_control_frame_parser #(
        .JOY_FRAME_DEPTH(JOY_DEPTH),
        .TILT_FRAME_DEPTH(TILT_DEPTH),
        .PACKET_DEPTH(PKT_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    rx_req_t rx_pending[$];
    parser_item_t expected_items[$];
    int fail_cnt = 0;
    int mismatch_cnt = 0;
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int src_wait = 0;
    int src_calm = 0;
    int sink_wait = 0;
    int sink_calm = 0;

    // parser state as the block should hold it
    logic [rcfp_pkg::MODE_W-1:0] cur_mode = rcfp_pkg::MODE_NONE;
    logic filter_done = 1'b0;
    logic left_on = 1'b0, right_on = 1'b0, tilt_on = 1'b0;
    logic pkt_collect = 1'b0, pkt_pending = 1'b0;
    logic left_seen = 1'b0, right_seen = 1'b0;
    logic [3:0] left_cnt = '0, right_cnt = '0;
    logic [4:0] tilt_cnt = '0, pkt_cnt = '0;
    logic [rcfp_pkg::BYTE_W-1:0] left_mem [JOY_DEPTH];
    logic [rcfp_pkg::BYTE_W-1:0] right_mem [JOY_DEPTH];
    logic [rcfp_pkg::BYTE_W-1:0] tilt_mem [TILT_DEPTH];
    logic [rcfp_pkg::BYTE_W-1:0] pkt_mem [PKT_DEPTH];

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic void parse_rx_byte(input logic [rcfp_pkg::BYTE_W-1:0] b,
                                          input logic ack);
        parser_item_t step_q[$];
        parser_item_t r;
        logic beep;
        logic left_done, right_done, left_emit, right_emit, pkt_done, tilt_done;
        int n;
        beep = 1'b0;
        left_done = 1'b0;
        right_done = 1'b0;
        left_emit = 1'b0;
        right_emit = 1'b0;
        pkt_done = 1'b0;
        tilt_done = 1'b0;

        if (ack)
            pkt_pending = 1'b0;
        if (b >= rcfp_pkg::CH_MODE_LO && b <= rcfp_pkg::CH_MODE_HI) begin
            cur_mode = 3'(b - rcfp_pkg::CH_MODE_LO) + 3'd1;
            beep = 1'b1;
        end
        if (!filter_done && cur_mode == rcfp_pkg::MODE_FILTER) begin
            cur_mode = rcfp_pkg::MODE_NONE;
            filter_done = 1'b1;
        end

        if (cur_mode != rcfp_pkg::MODE_TILT) begin
            if (b == rcfp_pkg::CH_LEFT)
                left_on = 1'b1;
            if (left_on) begin
                if (left_cnt < JOY_DEPTH) begin
                    left_mem[left_cnt] = b;
                    left_cnt++;
                end
                if (b == rcfp_pkg::CH_END) begin
                    left_done = 1'b1;
                    left_emit = left_seen;
                    left_seen = 1'b1;
                    left_on = 1'b0;
                end
            end
            if (b == rcfp_pkg::CH_RIGHT)
                right_on = 1'b1;
            if (right_on) begin
                if (right_cnt < JOY_DEPTH) begin
                    right_mem[right_cnt] = b;
                    right_cnt++;
                end
                if (b == rcfp_pkg::CH_END) begin
                    right_done = 1'b1;
                    right_emit = right_seen;
                    right_seen = 1'b1;
                    right_on = 1'b0;
                end
            end
            if (!pkt_collect) begin
                if (b == rcfp_pkg::CH_PACKET && !pkt_pending) begin
                    beep = 1'b1;
                    pkt_collect = 1'b1;
                    pkt_cnt = '0;
                end
            end else if (b == rcfp_pkg::CH_END) begin
                pkt_collect = 1'b0;
                pkt_pending = 1'b1;
                pkt_done = 1'b1;
            end else if (pkt_cnt < PKT_DEPTH) begin
                pkt_mem[pkt_cnt] = b;
                pkt_cnt++;
            end
        end else begin
            if (b == rcfp_pkg::CH_TILT) begin
                tilt_on = 1'b1;
                tilt_cnt = '0;
            end
            if (tilt_on) begin
                if (tilt_cnt < TILT_DEPTH) begin
                    tilt_mem[tilt_cnt] = b;
                    tilt_cnt++;
                end
                if (b == rcfp_pkg::CH_END) begin
                    tilt_done = 1'b1;
                    tilt_on = 1'b0;
                end
            end
        end

        // mode and ready are the values after the byte, shared by every item
        r = '{rcfp_pkg::KIND_STATUS, 8'h00, '0, cur_mode, beep, pkt_pending, 1'b0};
        step_q.push_back(r);
        if (left_done && left_emit)
            for (int i = 0; i < left_cnt; i++) begin
                r.kind = rcfp_pkg::KIND_LEFT; r.data = left_mem[i];
                r.pos = rcfp_pkg::POS_W'(i);
                step_q.push_back(r);
            end
        if (right_done && right_emit)
            for (int i = 0; i < right_cnt; i++) begin
                r.kind = rcfp_pkg::KIND_RIGHT; r.data = right_mem[i];
                r.pos = rcfp_pkg::POS_W'(i);
                step_q.push_back(r);
            end
        if (pkt_done)
            for (int i = 0; i < pkt_cnt; i++) begin
                r.kind = rcfp_pkg::KIND_PACKET; r.data = pkt_mem[i];
                r.pos = rcfp_pkg::POS_W'(i);
                step_q.push_back(r);
            end
        if (tilt_done)
            for (int i = 0; i < tilt_cnt; i++) begin
                r.kind = rcfp_pkg::KIND_TILT; r.data = tilt_mem[i];
                r.pos = rcfp_pkg::POS_W'(i);
                step_q.push_back(r);
            end

        if (left_done)
            left_cnt = '0;
        if (right_done)
            right_cnt = '0;
        if (tilt_done)
            tilt_cnt = '0;

        n = (step_q.size() > int'(rcfp_pkg::MAX_ITEMS)) ? int'(rcfp_pkg::MAX_ITEMS)
                                                         : step_q.size();
        for (int i = 0; i < n; i++) begin
            r = step_q[i];
            r.eof = (i == n - 1);
            expected_items.push_back(r);
        end
    endfunction

    // request side: hold each request until taken, then idle a random while
    always @(negedge clk) begin : drive_rx
        logic v;
        rx_req_t cur;
        if (rst_n) begin
            v = s_tvalid;
            if (s_tvalid && req_taken) begin
                v = 1'b0;
                src_wait = draw_wait(src_calm);
            end
            if (!v) begin
                if (src_wait > 0)
                    src_wait--;
                else if (rx_pending.size() != 0) begin
                    cur = rx_pending.pop_front();
                    s_tdata <= {7'b0, cur.ack, cur.rx};
                    v = 1'b1;
                end
            end
            s_tvalid <= v;
        end
    end

    // result side: stall a random while after each result
    always @(negedge clk) begin : drive_sink
        logic r;
        if (rst_n) begin
            if (m_tready && res_taken)
                sink_wait = draw_wait(sink_calm);
            if (sink_wait > 0) begin
                r = 1'b0;
                sink_wait--;
            end else
                r = 1'b1;
            m_tready <= r;
        end
    end

    always @(posedge clk) begin : monitor
        parser_item_t got, want;
        req_taken <= rst_n && s_tvalid && s_tready;
        res_taken <= rst_n && m_tvalid && m_tready;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata[7:0], s_tdata[8]);
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[7:0], m_tdata[12:8], m_tdata[15:13],
                        m_tdata[16], m_tdata[17], m_tlast};
                if (expected_items.size() == 0) begin
                    fail_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected result: kind %0d data %h pos %0d mode %0d",
                                 got.kind, got.data, got.pos, got.mode);
                end else begin
                    want = expected_items.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display("mismatch: exp kind %0d data %h pos %0d mode %0d %s",
                                     want.kind, want.data, want.pos, want.mode,
                                     $sformatf("beep %b rdy %b last %b",
                                               want.beep, want.ready, want.eof));
                            $display("          got kind %0d data %h pos %0d mode %0d %s",
                                     got.kind, got.data, got.pos, got.mode,
                                     $sformatf("beep %b rdy %b last %b",
                                               got.beep, got.ready, got.eof));
                        end
                    end
                end
            end
        end
    end

    function automatic logic [rcfp_pkg::BYTE_W-1:0] body_byte();
        logic [rcfp_pkg::BYTE_W-1:0] v;
        v = 8'($urandom_range(0, 255));
        // keep frames going: no terminator or mode letter inside a body
        while (v == rcfp_pkg::CH_END ||
               (v >= rcfp_pkg::CH_MODE_LO && v <= rcfp_pkg::CH_MODE_HI))
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic push_rx(input logic [rcfp_pkg::BYTE_W-1:0] b, input logic ack);
        rx_req_t q;
        q.rx = b;
        q.ack = ack;
        rx_pending.push_back(q);
    endtask

    function automatic logic rand_ack();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic add_body(input int len);
        for (int i = 0; i < len; i++)
            push_rx(body_byte(), rand_ack());
    endtask

    initial begin : stimulus
        int added;
        int len;
        foreach (DIRECTED[i])
            rx_pending.push_back(DIRECTED[i]);
        added = 0;
        while (added < RANDOM_ITEMS) begin
            len = rx_pending.size();
            case ($urandom_range(0, 9))
                0: push_rx(rcfp_pkg::CH_MODE_LO + 8'($urandom_range(0, 6)), rand_ack());
                1, 2: begin
                    push_rx(rcfp_pkg::CH_LEFT, rand_ack());
                    add_body($urandom_range(0, 12));
                    push_rx(rcfp_pkg::CH_END, rand_ack());
                end
                3, 4: begin
                    push_rx(rcfp_pkg::CH_RIGHT, rand_ack());
                    add_body($urandom_range(0, 12));
                    push_rx(rcfp_pkg::CH_END, rand_ack());
                end
                5: begin
                    push_rx(rcfp_pkg::CH_LEFT, rand_ack());
                    add_body($urandom_range(0, 4));
                    push_rx(rcfp_pkg::CH_RIGHT, rand_ack());
                    add_body($urandom_range(0, 10));
                    push_rx(rcfp_pkg::CH_END, rand_ack());
                end
                6, 7: begin
                    push_rx(rcfp_pkg::CH_PACKET, 1'($urandom_range(0, 1)));
                    add_body($urandom_range(0, 22));
                    push_rx(rcfp_pkg::CH_END, rand_ack());
                end
                8: begin
                    push_rx(rcfp_pkg::CH_MODE_LO + 8'd1, rand_ack());
                    push_rx(rcfp_pkg::CH_TILT, rand_ack());
                    add_body($urandom_range(0, 22));
                    push_rx(rcfp_pkg::CH_END, rand_ack());
                    push_rx(rcfp_pkg::CH_MODE_LO + 8'($urandom_range(2, 6)), rand_ack());
                end
                default: begin
                    repeat ($urandom_range(1, 3))
                        push_rx(8'($urandom_range(0, 255)), rand_ack());
                end
            endcase
            added += rx_pending.size() - len;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (rx_pending.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_items.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_items.size() != 0)
            fail_cnt++;
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
sv/rcfp_pkg.sv
sv/remote_control_frame_parser.sv
verif/tb.sv
